>>> rtl/acm_pkg.sv
// Shared types and constants for the cat map address unit.
// Used by every module under rtl; depends on nothing.
`default_nettype none

package acm_pkg;

	localparam int DIM_W       = 13;
	localparam int COORD_W     = 12;
	localparam int CHAN_W      = 8;
	localparam int ROUND_W     = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int DATA_W      = 2 * COORD_W + 3 * CHAN_W;
	localparam int MAX_DIM_DEF = 4096;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS    = 2'd0,
		REG_COLS    = 2'd1,
		REG_ROUNDS  = 2'd2,
		REG_INVERSE = 2'd3
	} cfg_reg_t;

	// (mult * addend) mod modulus, addend below modulus
	typedef struct packed {
		logic             start;
		logic [DIM_W:0]   mult;
		logic [DIM_W-1:0] addend;
		logic [DIM_W-1:0] modulus;
	} mm_req_t;

	typedef struct packed {
		logic             done;
		logic [DIM_W-1:0] result;
	} mm_rsp_t;

	typedef struct packed {
		logic             start;
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] cols;
	} sh_req_t;

	typedef struct packed {
		logic             done;
		logic [DIM_W-1:0] factor;
	} sh_rsp_t;

endpackage

`default_nettype wire

>>> rtl/arnold_cat_map_address_unit.sv
// Cat map address unit top level: stream ports, config registers, round sequencer.
// Depends on acm_pkg, acm_shear and acm_modmul.
//
// One pixel is taken at a time and its position is carried through round_count rounds of
// the generalized cat map; channel bytes and an out-of-image flag travel with it. Both
// reductions of a round run in bit-serial modular multipliers that consume one multiplier
// bit per cycle; in a forward round the two units run side by side, and in an inverse round
// they run one after the other, since the column step needs the new row first. The first
// item after a write to image_rows or image_cols also waits for the shear factor (binary
// gcd, then a 13-step division). An out-of-image pixel or a round count of zero skips the
// rounds and goes straight from the check state to the finish state. The next pixel is
// taken while the previous result waits.
`default_nettype none

module arnold_cat_map_address_unit import acm_pkg::*; #(
	parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [DATA_W-1:0]     s_tdata,   // pixel_row, pixel_col, chan_zero, chan_one, chan_two
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [DATA_W-1:0]     m_tdata,   // dest_row, dest_col, out_zero, out_one, out_two
	output logic [0:0]            m_tuser,   // range_error
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b00000001,
		ST_SHEAR  = 8'b00000010,
		ST_CHECK  = 8'b00000100,
		ST_LAUNCH = 8'b00001000,
		ST_WAIT_A = 8'b00010000,
		ST_MID    = 8'b00100000,
		ST_WAIT_B = 8'b01000000,
		ST_FINISH = 8'b10000000
	} state_t;

	state_t             state_q;
	logic [DIM_W-1:0]   rows_q;
	logic [DIM_W-1:0]   cols_q;
	logic [ROUND_W-1:0] rounds_q;
	logic               inverse_q;
	logic               shear_ready_q;
	logic [DIM_W-1:0]   shear_q;
	logic [ROUND_W-1:0] left_q;
	logic [DIM_W-1:0]   row_q;
	logic [DIM_W-1:0]   col_q;
	logic [CHAN_W-1:0]  chan0_q;
	logic [CHAN_W-1:0]  chan1_q;
	logic [CHAN_W-1:0]  chan2_q;
	logic               err_q;
	logic               m_valid_q;
	logic [DATA_W-1:0]  m_data_q;
	logic               m_err_q;

	logic [DIM_W-1:0]   rows_c;
	logic [DIM_W-1:0]   cols_c;
	logic [DIM_W-1:0]   one_c;
	logic [DIM_W:0]     sum_rc;
	logic [DIM_W:0]     fsum;
	logic [DIM_W:0]     fsum_sub;
	logic [DIM_W-1:0]   fwd_row;
	logic [DIM_W-1:0]   inv_row;
	logic [DIM_W-1:0]   inv_col;
	logic               accept;
	logic               out_free;
	logic               outside;
	logic               cfg_fire;

	mm_req_t mm0_req;
	mm_rsp_t mm0_rsp;
	mm_req_t mm1_req;
	mm_rsp_t mm1_rsp;
	sh_req_t sh_req;
	sh_rsp_t sh_rsp;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign out_free  = !m_valid_q || m_tready;

	always_comb begin
		if (rows_q == '0) begin
			rows_c = DIM_W'(1);
		end else if (32'(rows_q) > MAX_DIM) begin
			rows_c = DIM_W'(MAX_DIM);
		end else begin
			rows_c = rows_q;
		end
		if (cols_q == '0) begin
			cols_c = DIM_W'(1);
		end else if (32'(cols_q) > MAX_DIM) begin
			cols_c = DIM_W'(MAX_DIM);
		end else begin
			cols_c = cols_q;
		end
		one_c   = (cols_c == DIM_W'(1)) ? '0 : DIM_W'(1);
		outside = (row_q >= rows_c) || (col_q >= cols_c);

		sum_rc   = {1'b0, row_q} + {1'b0, col_q};
		fsum     = {1'b0, mm0_rsp.result} + {1'b0, row_q};
		fsum_sub = fsum - {1'b0, rows_c};
		fwd_row  = (fsum >= {1'b0, rows_c}) ? fsum_sub[DIM_W-1:0] : fsum[DIM_W-1:0];

		if (row_q >= mm0_rsp.result) begin
			inv_row = row_q - mm0_rsp.result;
		end else begin
			inv_row = row_q + (rows_c - mm0_rsp.result);
		end
		if (col_q >= mm1_rsp.result) begin
			inv_col = col_q - mm1_rsp.result;
		end else begin
			inv_col = col_q + (cols_c - mm1_rsp.result);
		end
	end

	always_comb begin
		sh_req.start   = accept && !shear_ready_q;
		sh_req.rows    = rows_c;
		sh_req.cols    = cols_c;

		mm0_req.start   = (state_q == ST_LAUNCH);
		mm0_req.mult    = inverse_q ? {1'b0, col_q} : sum_rc;
		mm0_req.addend  = shear_q;
		mm0_req.modulus = rows_c;

		mm1_req.start   = ((state_q == ST_LAUNCH) && !inverse_q) || (state_q == ST_MID);
		mm1_req.mult    = inverse_q ? {1'b0, row_q} : sum_rc;
		mm1_req.addend  = one_c;
		mm1_req.modulus = cols_c;
	end

	acm_shear u_shear (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sh_req),
		.rsp    (sh_rsp)
	);

	acm_modmul u_mm_row (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm0_req),
		.rsp    (mm0_rsp)
	);

	acm_modmul u_mm_col (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm1_req),
		.rsp    (mm1_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rows_q        <= DIM_W'(1);
			cols_q        <= DIM_W'(1);
			rounds_q      <= ROUND_W'(1);
			inverse_q     <= 1'b0;
			shear_ready_q <= 1'b0;
			shear_q       <= DIM_W'(1);
			left_q        <= '0;
			m_valid_q     <= 1'b0;
		end else begin
			if ((state_q == ST_FINISH) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= shear_ready_q ? ST_CHECK : ST_SHEAR;
					end
				end
				ST_SHEAR: begin
					if (sh_rsp.done) begin
						shear_q       <= (sh_rsp.factor == rows_c) ? '0 : sh_rsp.factor;
						shear_ready_q <= 1'b1;
						state_q       <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					left_q <= rounds_q;
					if (outside || (rounds_q == '0)) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_LAUNCH;
					end
				end
				ST_LAUNCH: state_q <= ST_WAIT_A;
				ST_WAIT_A: begin
					if (mm0_rsp.done) begin
						if (inverse_q) begin
							state_q <= ST_MID;
						end else begin
							left_q  <= left_q - 1'b1;
							state_q <= (left_q == ROUND_W'(1)) ? ST_FINISH : ST_LAUNCH;
						end
					end
				end
				ST_MID: state_q <= ST_WAIT_B;
				ST_WAIT_B: begin
					if (mm1_rsp.done) begin
						left_q  <= left_q - 1'b1;
						state_q <= (left_q == ROUND_W'(1)) ? ST_FINISH : ST_LAUNCH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_fire) begin
				case (cfg_reg_t'(cfg_index))
					REG_ROWS: begin
						rows_q        <= cfg_data[DIM_W-1:0];
						shear_ready_q <= 1'b0;
					end
					REG_COLS: begin
						cols_q        <= cfg_data[DIM_W-1:0];
						shear_ready_q <= 1'b0;
					end
					REG_ROUNDS:  rounds_q  <= cfg_data[ROUND_W-1:0];
					REG_INVERSE: inverse_q <= cfg_data[0];
					default: begin
						rounds_q <= rounds_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					row_q   <= {1'b0, s_tdata[COORD_W-1:0]};
					col_q   <= {1'b0, s_tdata[2*COORD_W-1:COORD_W]};
					chan0_q <= s_tdata[2*COORD_W+CHAN_W-1:2*COORD_W];
					chan1_q <= s_tdata[2*COORD_W+2*CHAN_W-1:2*COORD_W+CHAN_W];
					chan2_q <= s_tdata[2*COORD_W+3*CHAN_W-1:2*COORD_W+2*CHAN_W];
				end
			end
			ST_CHECK: err_q <= outside;
			ST_WAIT_A: begin
				if (mm0_rsp.done) begin
					if (inverse_q) begin
						row_q <= inv_row;
					end else begin
						row_q <= fwd_row;
						col_q <= mm1_rsp.result;
					end
				end
			end
			ST_WAIT_B: begin
				if (mm1_rsp.done) begin
					col_q <= inv_col;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					m_data_q <= {chan2_q, chan1_q, chan0_q,
						col_q[COORD_W-1:0], row_q[COORD_W-1:0]};
					m_err_q  <= err_q;
				end
			end
			default: begin
				err_q <= err_q;
			end
		endcase
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_err_q;

`ifndef ASSERT_OFF
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a pixel is in flight");

	a_cfg_drops_shear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && ((cfg_index == REG_ROWS) || (cfg_index == REG_COLS))
		|=> !shear_ready_q)
		else $error("dimension write left stale shear factor");

	a_row_unit_done: assert property (@(posedge clk) disable iff (!arst_n)
		mm0_rsp.done |-> (state_q == ST_WAIT_A))
		else $error("row unit finished outside its wait state");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) && m_valid_q && !m_tready
		|=> m_valid_q && (state_q == ST_FINISH))
		else $error("pending result overwritten");

	a_launch_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LAUNCH) |-> (left_q != '0))
		else $error("round launched with none left");
`endif

endmodule

`default_nettype wire

>>> rtl/acm_modmul.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Depends on acm_pkg.
`default_nettype none

module acm_modmul import acm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  mm_req_t req,
	output mm_rsp_t rsp
);

	localparam int MULT_W = DIM_W + 1;
	localparam int CNT_W  = $clog2(MULT_W);

	logic [MULT_W-1:0] mult_q;
	logic [DIM_W-1:0]  addend_q;
	logic [DIM_W-1:0]  modulus_q;
	logic [DIM_W-1:0]  acc_q;
	logic [DIM_W-1:0]  acc_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIM_W:0]    dbl;
	logic [DIM_W:0]    dbl_red;
	logic [DIM_W:0]    sum;
	logic [DIM_W:0]    sum_red;

	always_comb begin
		dbl = {acc_q, 1'b0};
		if (dbl >= {1'b0, modulus_q}) begin
			dbl_red = dbl - {1'b0, modulus_q};
		end else begin
			dbl_red = dbl;
		end
		sum = {1'b0, dbl_red[DIM_W-1:0]} + {1'b0, addend_q};
		if (sum >= {1'b0, modulus_q}) begin
			sum_red = sum - {1'b0, modulus_q};
		end else begin
			sum_red = sum;
		end
		acc_d = mult_q[MULT_W-1] ? sum_red[DIM_W-1:0] : dbl_red[DIM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MULT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mult_q    <= req.mult;
			addend_q  <= req.addend;
			modulus_q <= req.modulus;
			acc_q     <= '0;
		end else if (busy_q) begin
			mult_q <= {mult_q[MULT_W-2:0], 1'b0};
			acc_q  <= acc_d;
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = acc_q;

endmodule

`default_nettype wire

>>> rtl/acm_shear.sv
// Shear factor unit: rows / gcd(rows, cols) by binary gcd, then restoring division.
// Depends on acm_pkg.
`default_nettype none

module acm_shear import acm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  sh_req_t req,
	output sh_rsp_t rsp
);

	localparam int K_W   = $clog2(DIM_W);
	localparam int CNT_W = $clog2(DIM_W);

	typedef enum logic [2:0] {
		SH_IDLE = 3'b001,
		SH_GCD  = 3'b010,
		SH_DIV  = 3'b100
	} sh_state_t;

	sh_state_t        state_q;
	logic             done_q;
	logic [DIM_W-1:0] a_q;
	logic [DIM_W-1:0] b_q;
	logic [K_W-1:0]   k_q;
	logic [DIM_W-1:0] num_q;
	logic [DIM_W-1:0] div_q;
	logic [DIM_W-1:0] rem_q;
	logic [DIM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIM_W:0]   trial;
	logic [DIM_W:0]   trial_sub;
	logic             fits;

	always_comb begin
		trial     = {rem_q, num_q[DIM_W-1]};
		fits      = (trial >= {1'b0, div_q});
		trial_sub = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				SH_IDLE: begin
					if (req.start) begin
						state_q <= SH_GCD;
					end
				end
				SH_GCD: begin
					if (b_q == '0) begin
						state_q <= SH_DIV;
					end
				end
				SH_DIV: begin
					if (cnt_q == CNT_W'(DIM_W - 1)) begin
						state_q <= SH_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= SH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SH_IDLE: begin
				if (req.start) begin
					a_q   <= req.rows;
					b_q   <= req.cols;
					num_q <= req.rows;
					k_q   <= '0;
				end
			end
			SH_GCD: begin
				if (b_q == '0) begin
					div_q <= a_q << k_q;
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= '0;
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_q >= b_q) begin
					a_q <= b_q;
					b_q <= a_q - b_q;
				end else begin
					b_q <= b_q - a_q;
				end
			end
			SH_DIV: begin
				rem_q <= fits ? trial_sub[DIM_W-1:0] : trial[DIM_W-1:0];
				quo_q <= {quo_q[DIM_W-2:0], fits};
				num_q <= {num_q[DIM_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
				a_q <= a_q;
			end
		endcase
	end

	assign rsp.done   = done_q;
	assign rsp.factor = quo_q;

endmodule

`default_nettype wire

>>> sim/arnold_cat_map_address_unit_tb.sv
// Testbench for arnold_cat_map_address_unit: streams pixels through the cat map
// and checks each destination beat against an in-bench computation of the rounds.
// Depends on acm_pkg and the RTL under rtl.

module arnold_cat_map_address_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import acm_pkg::*;

	typedef struct packed {
		logic [CHAN_W-1:0]  chan_two;
		logic [CHAN_W-1:0]  chan_one;
		logic [CHAN_W-1:0]  chan_zero;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} pixel_t;

	typedef struct {
		pixel_t beat;
		logic   range_error;
	} dest_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [DATA_W-1:0]     s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [DATA_W-1:0]     m_tdata;
	logic [0:0]            m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [DIM_W-1:0]   rows_reg = 13'd1;
	logic [DIM_W-1:0]   cols_reg = 13'd1;
	logic [ROUND_W-1:0] rounds_reg = 16'd1;
	logic               inverse_reg = 1'b0;

	dest_t pending_dests[$];
	int    fail_count = 0;
	int    sent_count = 0;
	bit    steady = 1'b0;
	bit    hold_request = 1'b0;

	arnold_cat_map_address_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint unsigned dim_used(input logic [DIM_W-1:0] v);
		if (v == 0) return 1;
		if (32'(v) > MAX_DIM_DEF) return 64'(MAX_DIM_DEF);
		return 64'(v);
	endfunction

	function automatic dest_t map_pixel(input pixel_t px);
		longint unsigned nr, nc, q, a, b, t, y, x, ny;
		int unsigned n;
		dest_t res;
		nr = dim_used(rows_reg);
		nc = dim_used(cols_reg);
		a = nr;
		b = nc;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		q = (nr / a) & 64'h1FFF;
		res.beat = px;
		res.range_error = 1'b0;
		y = 64'(px.row);
		x = 64'(px.col);
		if (y >= nr || x >= nc) begin
			res.range_error = 1'b1;
		end else begin
			for (n = 0; n < 32'(rounds_reg); n++) begin
				if (!inverse_reg) begin
					ny = (q * x + (q + 1) * y) % nr;
					x = (x + y) % nc;
				end else begin
					ny = (y + nr - (q * x) % nr) % nr;
					x = (x + nc - ny % nc) % nc;
				end
				y = ny;
			end
			res.beat.row = y[COORD_W-1:0];
			res.beat.col = x[COORD_W-1:0];
		end
		return res;
	endfunction

	function automatic pixel_t make_pixel(input int r, input int c, input int ch);
		pixel_t px;
		px.row = COORD_W'(r);
		px.col = COORD_W'(c);
		px.chan_zero = CHAN_W'(ch);
		px.chan_one = CHAN_W'(~ch);
		px.chan_two = CHAN_W'(ch ^ 8'h5A);
		return px;
	endfunction

	function automatic pixel_t rand_pixel(input bit in_image);
		pixel_t px;
		px = pixel_t'(DATA_W'({$urandom, $urandom}));
		if (in_image) begin
			px.row = COORD_W'(64'($urandom) % dim_used(rows_reg));
			px.col = COORD_W'(64'($urandom) % dim_used(cols_reg));
		end
		return px;
	endfunction

	function automatic logic [DIM_W-1:0] rand_dim();
		case ($urandom_range(9))
			0: return 13'd1;
			1: return 13'd4096;
			2: return 13'd0;
			3: return 13'($urandom_range(4097, 8191));
			4, 5, 6: return 13'($urandom_range(1, 64));
			default: return 13'($urandom_range(1, 4096));
		endcase
	endfunction

	task automatic send_pixel(input pixel_t px);
		while (!steady && $urandom_range(99) < 13) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
		pending_dests.push_back(map_pixel(px));
		sent_count++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_dests.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] rows_data, cols_data,
			rounds_data, mode_data);
		logic [CFG_DATA_W-1:0] vals [4];
		cfg_reg_t idx [4];
		int i;
		vals = '{rows_data, cols_data, rounds_data, mode_data};
		idx = '{REG_ROWS, REG_COLS, REG_ROUNDS, REG_INVERSE};
		wait_drained();
		for (i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx[i])
				REG_ROWS:    rows_reg = vals[i][DIM_W-1:0];
				REG_COLS:    cols_reg = vals[i][DIM_W-1:0];
				REG_ROUNDS:  rounds_reg = vals[i][ROUND_W-1:0];
				REG_INVERSE: inverse_reg = vals[i][0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want !== got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic test_reset_defaults();
		send_pixel(make_pixel(0, 0, 8'h00));
		send_pixel(make_pixel(0, 1, 8'h81));
		send_pixel(make_pixel(4095, 4095, 8'hFF));
	endtask

	task automatic test_full_frame();
		configure(16'd4096, 16'd4096, 16'd1, 16'd0);
		send_pixel(make_pixel(4095, 4095, 8'hAA));
		send_pixel(make_pixel(0, 4095, 8'h55));
		send_pixel(make_pixel(4095, 0, 8'hFF));
		send_pixel(make_pixel(0, 0, 8'h00));
		configure(16'd4096, 16'd4096, 16'd1, 16'd1);
		send_pixel(make_pixel(4095, 4095, 8'h0F));
		send_pixel(make_pixel(1, 4094, 8'hF0));
	endtask

	task automatic test_clamped_dims();
		configure(16'h0000, 16'hFFFF, 16'd3, 16'd0);
		send_pixel(make_pixel(0, 4095, 8'h3C));
		send_pixel(make_pixel(1, 0, 8'hC3));
		send_pixel(make_pixel(0, 17, 8'h01));
		configure(16'd5000, 16'd3, 16'd2, 16'd1);
		send_pixel(make_pixel(4095, 2, 8'h7E));
		send_pixel(make_pixel(100, 3, 8'hE7));
	endtask

	task automatic test_zero_rounds();
		configure(16'd37, 16'd23, 16'd0, 16'd0);
		send_pixel(make_pixel(36, 22, 8'h12));
		send_pixel(make_pixel(5, 7, 8'h34));
		configure(16'd37, 16'd23, 16'd0, 16'd1);
		send_pixel(make_pixel(36, 0, 8'h56));
		send_pixel(make_pixel(0, 22, 8'h78));
	endtask

	task automatic test_random_phases();
		int n;
		logic [ROUND_W-1:0] rounds;
		while (sent_count < 1000) begin
			rounds = ($urandom_range(99) < 80) ? 16'($urandom_range(0, 6))
				: 16'($urandom_range(7, 16));
			configure({3'($urandom), rand_dim()}, {3'($urandom), rand_dim()}, rounds,
				{15'($urandom), 1'($urandom)});
			n = $urandom_range(20, 70);
			repeat (n) send_pixel(rand_pixel($urandom_range(99) < 85));
		end
	endtask

	task automatic test_steady_stream();
		steady = 1'b1;
		configure(16'd24, 16'd40, 16'd2, 16'd0);
		repeat (60) send_pixel(rand_pixel($urandom_range(99) < 90));
		wait_drained();
		steady = 1'b0;
	endtask

	task automatic test_backpressure();
		configure(16'd9, 16'd12, 16'd1, 16'd0);
		hold_request = 1'b1;
		repeat (40) send_pixel(rand_pixel(1'b1));
		wait_drained();
		repeat (20) send_pixel(rand_pixel(1'b1));
	endtask

	task automatic test_max_rounds();
		configure(16'd7, 16'd10, 16'hFFFF, 16'd0);
		send_pixel(make_pixel(6, 9, 8'h99));
		send_pixel(make_pixel(7, 0, 8'h66));
	endtask

	initial begin
		int hold_left;
		dest_t want;
		pixel_t got;
		hold_left = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_dests.size() == 0) begin
					$error("result beat with no pending pixel");
					fail_count++;
				end else begin
					want = pending_dests.pop_front();
					got = pixel_t'(m_tdata);
					check_field("dest_row", 32'(want.beat.row), 32'(got.row));
					check_field("dest_col", 32'(want.beat.col), 32'(got.col));
					check_field("out_zero", 32'(want.beat.chan_zero), 32'(got.chan_zero));
					check_field("out_one", 32'(want.beat.chan_one), 32'(got.chan_one));
					check_field("out_two", 32'(want.beat.chan_two), 32'(got.chan_two));
					check_field("range_error", 32'(want.range_error), 32'(m_tuser[0]));
				end
			end
			if (hold_request) begin
				hold_left = 300;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(99) >= 13);
			end
		end
	end

	initial begin
		#150_000_000;
		$display("[arnold_cat_map_address_unit] ERROR");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_ROWS;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_full_frame();
		test_clamped_dims();
		test_zero_rounds();
		test_random_phases();
		test_steady_stream();
		test_backpressure();
		test_max_rounds();
		wait_drained();
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending_dests.size() == 0) begin
			$display("[arnold_cat_map_address_unit] OK");
		end else begin
			$display("[arnold_cat_map_address_unit] ERROR");
		end
		$finish;
	end

endmodule
